/* hdl/sdi_pkg.sv */
// Shared types, codes and command tables for the SD card SPI-mode start-up sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package sdi_pkg;

	localparam int ATTEMPT_CNT_W_DEFAULT = 16;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_MAX_ATTEMPTS   = 1'b0;
	localparam logic REG_POWER_UP_BYTES = 1'b1;

	localparam logic [15:0] MAX_ATTEMPTS_RST   = 16'd500;
	localparam logic [7:0]  POWER_UP_BYTES_RST = 8'd10;

	// Status codes
	localparam logic [1:0] ST_BUSY      = 2'd0;
	localparam logic [1:0] ST_READY     = 2'd1;
	localparam logic [1:0] ST_CMD0_TO   = 2'd2;
	localparam logic [1:0] ST_ACMD41_TO = 2'd3;

	// Command slots
	localparam logic [2:0] CMD_0      = 3'd0;
	localparam logic [2:0] CMD_8      = 3'd1;
	localparam logic [2:0] CMD_58     = 3'd2;
	localparam logic [2:0] CMD_55     = 3'd3;
	localparam logic [2:0] CMD_ACMD41 = 3'd4;

	localparam logic [7:0] SPI_IDLE_BYTE = 8'hFF;

	typedef struct packed {
		logic [15:0] max_attempts;
		logic [7:0]  power_up_bytes;
	} sdi_cfg_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       select_active;
		logic [1:0] status;
	} sdi_result_t;

	// Byte pos of command c
	function automatic logic [7:0] cmd_byte(input logic [2:0] c, input logic [3:0] pos);
		logic [7:0] b;
		b = 8'h00;
		case (c)
			CMD_0: begin
				case (pos)
					4'd0: b = 8'h40;
					4'd5: b = 8'h95;
					4'd6: b = 8'hFF;
					default: b = 8'h00;
				endcase
			end
			CMD_8: begin
				case (pos)
					4'd0: b = 8'h48;
					4'd3: b = 8'h01;
					4'd4: b = 8'hAA;
					4'd5: b = 8'h87;
					default: b = 8'h00;
				endcase
			end
			CMD_58: begin
				case (pos)
					4'd0: b = 8'h7A;
					4'd5: b = 8'h75;
					default: b = 8'h00;
				endcase
			end
			CMD_55: begin
				case (pos)
					4'd0: b = 8'h77;
					4'd5: b = 8'h95;
					default: b = 8'h00;
				endcase
			end
			CMD_ACMD41: begin
				case (pos)
					4'd0: b = 8'h69;
					4'd5: b = 8'h5F;
					default: b = 8'h00;
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] cmd_len(input logic [2:0] c);
		return (c == CMD_0) ? 4'd7 : 4'd6;
	endfunction

	function automatic logic [3:0] read_count(input logic [2:0] c);
		logic [3:0] n;
		case (c)
			CMD_0:   n = 4'd2;
			CMD_8:   n = 4'd6;
			CMD_58:  n = 4'd11;
			CMD_55:  n = 4'd3;
			default: n = 4'd4;
		endcase
		return n;
	endfunction

	// Polls that end early on a match
	function automatic logic stop_hit(input logic [2:0] c, input logic [7:0] rx);
		logic h;
		case (c)
			CMD_0:               h = (rx == 8'h01);
			CMD_55, CMD_ACMD41:  h = (rx == 8'h00);
			default:             h = 1'b0;
		endcase
		return h;
	endfunction

endpackage
`default_nettype wire

/* hdl/sd_spi_card_initializer.sv */
// Top level of the SD card SPI-mode start-up sequencer: beat registers and handshake.
// Depends on sdi_pkg, sdi_regs and sdi_seq.
`default_nettype none
// Host-side sequencer that walks an SD card through SPI-mode start-up: power-up dummy
// bytes with chip select high, CMD0 (retried up to max_attempts), CMD8, CMD58 and
// CMD55/ACMD41 pairs until ACMD41 answers 0x00. The host sends a start beat (kind 0)
// and then, after each SPI exchange it performs, a beat with kind 1 and the byte it
// received; every input beat yields exactly one result beat carrying the next byte to
// shift out, whether an exchange is wanted, chip select, and status (busy, ready, CMD0
// timeout, ACMD41 timeout). A start beat restarts the sequence from any point.
// Throughput is one beat per clock while out_ready stays high: an input register feeds
// the sequencer step, whose result lands in an output register. The only stall source
// is out_ready back-pressure on that output register. No clearing pass follows reset.
// Registers (APB, byte address): 0x0 max_attempts [15:0], reset 500;
// 0x4 power_up_bytes [7:0], reset 10. Write them only while the block is idle.
module sd_spi_card_initializer
	import sdi_pkg::*;
#(
	parameter int ATTEMPT_COUNTER_WIDTH = ATTEMPT_CNT_W_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB config
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input beats
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  rx_byte,
	// result beats
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  tx_byte,
	output logic             tx_valid,
	output logic             select_active,
	output logic      [1:0]  status
);

	sdi_cfg_t    cfg;
	sdi_result_t step_res;
	sdi_result_t res_q;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] rx_s1;
	logic       out_valid_q;
	logic       step;

	sdi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step the sequencer when a beat is held and the output slot frees up
	assign step     = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input register, loaded on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			rx_s1   <= rx_byte;
		end
	end

	sdi_seq #(
		.ATTEMPT_CNT_W (ATTEMPT_COUNTER_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.kind    (kind_s1),
		.rx_byte (rx_s1),
		.cfg     (cfg),
		.result  (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= step_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_byte       = res_q.tx_byte;
	assign tx_valid      = res_q.tx_valid;
	assign select_active = res_q.select_active;
	assign status        = res_q.status;

`ifndef SYNTH
	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("sequencer step did not produce a result beat");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(kind_s1) && $stable(rx_s1))
		else $error("held input beat lost or changed");

	a_no_xfer_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.tx_valid |-> res_q.tx_byte == SPI_IDLE_BYTE
			&& !res_q.select_active)
		else $error("no exchange requested but byte or select not idle");

	a_done_no_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_BUSY |-> !res_q.tx_valid)
		else $error("exchange requested with a final status");
`endif

endmodule
`default_nettype wire

/* hdl/sdi_regs.sv */
// APB-style configuration registers: max_attempts and power_up_bytes.
// Depends on sdi_pkg.
`default_nettype none
module sdi_regs
	import sdi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output sdi_cfg_t         cfg
);

	logic [15:0] max_attempts_q;
	logic [7:0]  power_up_bytes_q;
	logic        reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q   <= MAX_ATTEMPTS_RST;
			power_up_bytes_q <= POWER_UP_BYTES_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_ATTEMPTS:   max_attempts_q   <= pwdata[15:0];
				REG_POWER_UP_BYTES: power_up_bytes_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_ATTEMPTS:   prdata = {16'd0, max_attempts_q};
			REG_POWER_UP_BYTES: prdata = {24'd0, power_up_bytes_q};
		endcase
	end

	assign cfg = '{max_attempts: max_attempts_q, power_up_bytes: power_up_bytes_q};

endmodule
`default_nettype wire

/* hdl/sdi_seq.sv */
// Start-up sequence state and one-step next-state/result logic.
// Depends on sdi_pkg; stepped by the top level once per input beat.
`default_nettype none
module sdi_seq
	import sdi_pkg::*;
#(
	parameter int ATTEMPT_CNT_W = ATTEMPT_CNT_W_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        kind,
	input  wire logic [7:0]  rx_byte,
	input  wire sdi_cfg_t    cfg,
	output sdi_result_t      result
);

	localparam int CW = (ATTEMPT_CNT_W > 16) ? ATTEMPT_CNT_W : 16;
	localparam logic [ATTEMPT_CNT_W-1:0] ATT_MAX = '1;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_CMD0_TX   = 4'd1,
		PH_CMD0_RX   = 4'd2,
		PH_CMD8_TX   = 4'd3,
		PH_CMD8_RX   = 4'd4,
		PH_CMD58_TX  = 4'd5,
		PH_CMD58_RX  = 4'd6,
		PH_CMD55_TX  = 4'd7,
		PH_CMD55_RX  = 4'd8,
		PH_ACMD41_TX = 4'd9,
		PH_ACMD41_RX = 4'd10,
		PH_POWER     = 4'd11,
		PH_READY     = 4'd12,
		PH_FAIL0     = 4'd13,
		PH_FAIL41    = 4'd14
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [3:0]               pos_q, pos_d;
	logic [3:0]               poll_q, poll_d;
	logic [ATTEMPT_CNT_W-1:0] att_q, att_d;
	logic [7:0]               dummy_q, dummy_d;

	logic [3:0]               ph_m1;
	logic [2:0]               c;
	logic [3:0]               pos_inc;
	logic [3:0]               poll_inc;
	logic                     hit;
	logic [ATTEMPT_CNT_W-1:0] att_inc;
	logic                     att_done;
	logic [1:0]               cur_status;
	sdi_result_t              idle_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			poll_q  <= '0;
			att_q   <= '0;
			dummy_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			poll_q  <= poll_d;
			att_q   <= att_d;
			dummy_q <= dummy_d;
		end
	end

	assign ph_m1    = phase_q - 4'd1;
	assign c        = ph_m1[3:1];
	assign pos_inc  = pos_q + 4'd1;
	assign poll_inc = poll_q + 4'd1;
	assign hit      = stop_hit(c, rx_byte);

	// saturating retry count; all-ones also ends the loop
	assign att_inc  = (att_q == ATT_MAX) ? att_q : att_q + 1'b1;
	assign att_done = (CW'(att_inc) >= CW'(cfg.max_attempts)) || (att_inc == ATT_MAX);

	always_comb begin
		case (phase_q)
			PH_READY:  cur_status = ST_READY;
			PH_FAIL0:  cur_status = ST_CMD0_TO;
			PH_FAIL41: cur_status = ST_ACMD41_TO;
			default:   cur_status = ST_BUSY;
		endcase
	end

	assign idle_res = '{tx_byte: SPI_IDLE_BYTE, tx_valid: 1'b0, select_active: 1'b0,
		status: cur_status};

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		poll_d  = poll_q;
		att_d   = att_q;
		dummy_d = dummy_q;
		result  = idle_res;
		if (!kind) begin
			phase_d = PH_POWER;
			pos_d   = '0;
			poll_d  = '0;
			att_d   = '0;
			dummy_d = 8'd1;
			result  = '{SPI_IDLE_BYTE, 1'b1, 1'b0, ST_BUSY};
		end else begin
			unique case (phase_q) inside
				PH_POWER: begin
					if (dummy_q < cfg.power_up_bytes) begin
						dummy_d = dummy_q + 8'd1;
						result  = '{SPI_IDLE_BYTE, 1'b1, 1'b0, ST_BUSY};
					end else begin
						att_d   = '0;
						phase_d = PH_CMD0_TX;
						pos_d   = '0;
						poll_d  = '0;
						result  = '{cmd_byte(CMD_0, 4'd0), 1'b1, 1'b1, ST_BUSY};
					end
				end
				PH_CMD0_TX, PH_CMD8_TX, PH_CMD58_TX, PH_CMD55_TX, PH_ACMD41_TX: begin
					pos_d = pos_inc;
					if (pos_inc < cmd_len(c)) begin
						result = '{cmd_byte(c, pos_inc), 1'b1, 1'b1, ST_BUSY};
					end else begin
						phase_d = phase_t'(phase_q + 4'd1);
						poll_d  = '0;
						result  = '{SPI_IDLE_BYTE, 1'b1, 1'b1, ST_BUSY};
					end
				end
				PH_CMD0_RX, PH_CMD8_RX, PH_CMD58_RX, PH_CMD55_RX, PH_ACMD41_RX: begin
					poll_d = poll_inc;
					if (!hit && (poll_inc < read_count(c))) begin
						result = '{SPI_IDLE_BYTE, 1'b1, 1'b1, ST_BUSY};
					end else begin
						pos_d  = '0;
						poll_d = '0;
						case (c)
							CMD_0: begin
								if (hit) begin
									phase_d = PH_CMD8_TX;
									result  = '{cmd_byte(CMD_8, 4'd0), 1'b1, 1'b1, ST_BUSY};
								end else begin
									att_d = att_inc;
									if (att_done) begin
										phase_d = PH_FAIL0;
										poll_d  = poll_inc;
										pos_d   = pos_q;
										result  = '{SPI_IDLE_BYTE, 1'b0, 1'b0, ST_CMD0_TO};
									end else begin
										phase_d = PH_CMD0_TX;
										result  = '{cmd_byte(CMD_0, 4'd0), 1'b1, 1'b1, ST_BUSY};
									end
								end
							end
							CMD_8: begin
								phase_d = PH_CMD58_TX;
								result  = '{cmd_byte(CMD_58, 4'd0), 1'b1, 1'b1, ST_BUSY};
							end
							CMD_58: begin
								att_d   = '0;
								phase_d = PH_CMD55_TX;
								result  = '{cmd_byte(CMD_55, 4'd0), 1'b1, 1'b1, ST_BUSY};
							end
							CMD_55: begin
								phase_d = PH_ACMD41_TX;
								result  = '{cmd_byte(CMD_ACMD41, 4'd0), 1'b1, 1'b1, ST_BUSY};
							end
							default: begin
								if (hit) begin
									phase_d = PH_READY;
									poll_d  = poll_inc;
									pos_d   = pos_q;
									result  = '{SPI_IDLE_BYTE, 1'b0, 1'b0, ST_READY};
								end else begin
									att_d = att_inc;
									if (att_done) begin
										phase_d = PH_FAIL41;
										poll_d  = poll_inc;
										pos_d   = pos_q;
										result  = '{SPI_IDLE_BYTE, 1'b0, 1'b0, ST_ACMD41_TO};
									end else begin
										phase_d = PH_CMD55_TX;
										result  = '{cmd_byte(CMD_55, 4'd0), 1'b1, 1'b1, ST_BUSY};
									end
								end
							end
						endcase
					end
				end
				default: result = idle_res;
			endcase
		end
	end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the SD card SPI-mode start-up sequencer.
// Streams host-side start and exchange beats against a card that answers the polls,
// and scores every result beat with a predictor of its own. Needs sdi_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sdi_pkg::*;

	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipeline
	localparam int STALL_LIMIT = 3000;  // cycles without any handshake before giving up

	// Sequencer phases as tracked by the predictor. Odd phases 1..9 shift out a
	// command frame, even phases 2..10 read or poll the answer of that command.
	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_CMD0_POLL   = 4'd2;
	localparam logic [3:0] PH_LAST_CMD    = 4'd10;
	localparam logic [3:0] PH_CMD55_POLL  = 4'd8;
	localparam logic [3:0] PH_ACMD41_POLL = 4'd10;
	localparam logic [3:0] PH_POWER       = 4'd11;
	localparam logic [3:0] PH_READY       = 4'd12;
	localparam logic [3:0] PH_FAIL_CMD0   = 4'd13;
	localparam logic [3:0] PH_FAIL_ACMD41 = 4'd14;

	localparam logic [15:0] TRIES_SAT = 16'hFFFF;

	// Command frames, first byte in the top octet; the 6-byte ones are padded.
	localparam logic [55:0] FRAME_CMD0   = 56'h40_00_00_00_00_95_FF;
	localparam logic [55:0] FRAME_CMD8   = 56'h48_00_00_01_AA_87_00;
	localparam logic [55:0] FRAME_CMD58  = 56'h7A_00_00_00_00_75_00;
	localparam logic [55:0] FRAME_CMD55  = 56'h77_00_00_00_00_95_00;
	localparam logic [55:0] FRAME_ACMD41 = 56'h69_00_00_00_00_5F_00;
	// Reads or polls after each command, 4 bits per slot, CMD0 in the low nibble
	localparam logic [19:0] POLL_LIMITS  = {4'd4, 4'd3, 4'd11, 4'd6, 4'd2};

	localparam logic [7:0] CMD0_IDLE_ANSWER = 8'h01;
	localparam logic [7:0] CARD_OK_ANSWER   = 8'h00;

	// ---------------------------------------------------------------- DUT wiring
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [7:0]  rx_byte = 8'hFF;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  tx_byte;
	logic        tx_valid;
	logic        select_active;
	logic [1:0]  status;

	sd_spi_card_initializer uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.tx_valid(tx_valid),
		.select_active(select_active),
		.status(status)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	// Mirror of the sequencer state, advanced once per accepted input beat.
	logic [3:0]  seq_phase = PH_IDLE;
	logic [3:0]  frame_pos = 4'd0;
	logic [3:0]  poll_no = 4'd0;
	logic [15:0] tries = 16'd0;         // failed attempts, saturating
	logic [7:0]  dummies = 8'd0;
	logic [15:0] cfg_max_attempts = MAX_ATTEMPTS_RST;
	logic [7:0]  cfg_power_up = POWER_UP_BYTES_RST;

	sdi_result_t predicted_beats[$];    // result beats still owed by the block

	// Scoreboard / pacing state
	int mismatches = 0;
	int idle_run = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	bit last_try_card = 1'b0;           // card answers only on the final attempt
	int holds_requested = 0;
	int holds_served = 0;
	int hold_left = 0;
	int pattern_left = 0;
	int pattern_mode = 0;

	function automatic logic [7:0] frame_byte(input logic [2:0] c, input logic [3:0] pos);
		logic [55:0] f;
		case (c)
			CMD_0:   f = FRAME_CMD0;
			CMD_8:   f = FRAME_CMD8;
			CMD_58:  f = FRAME_CMD58;
			CMD_55:  f = FRAME_CMD55;
			default: f = FRAME_ACMD41;
		endcase
		return f[8 * (6 - int'(pos)) +: 8];
	endfunction

	function automatic sdi_result_t spi_beat(input logic [7:0] b, input logic sel);
		return {b, 1'b1, sel, ST_BUSY};
	endfunction

	// No exchange wanted: idle byte, select off, status from the phase
	function automatic sdi_result_t quiet_beat();
		logic [1:0] st;
		case (seq_phase)
			PH_READY:       st = ST_READY;
			PH_FAIL_CMD0:   st = ST_CMD0_TO;
			PH_FAIL_ACMD41: st = ST_ACMD41_TO;
			default:        st = ST_BUSY;
		endcase
		return {SPI_IDLE_BYTE, 1'b0, 1'b0, st};
	endfunction

	function automatic sdi_result_t open_command(input logic [2:0] c);
		seq_phase = {c, 1'b1};
		frame_pos = 4'd0;
		poll_no = 4'd0;
		return spi_beat(frame_byte(c, 4'd0), 1'b1);
	endfunction

	// One more failed attempt; true once the retry budget is spent
	function automatic logic attempts_spent();
		if (tries != TRIES_SAT)
			tries = tries + 16'd1;
		return (tries >= cfg_max_attempts) || (tries == TRIES_SAT);
	endfunction

	function automatic sdi_result_t sequencer_step(input logic k, input logic [7:0] rx);
		sdi_result_t r;
		logic [2:0] c;
		logic hit;
		r = quiet_beat();
		c = 3'((seq_phase - 4'd1) >> 1);
		if (!k) begin
			// start restarts from the power-up dummies, whatever the phase
			seq_phase = PH_POWER;
			frame_pos = 4'd0;
			poll_no = 4'd0;
			tries = 16'd0;
			dummies = 8'd1;
			r = spi_beat(SPI_IDLE_BYTE, 1'b0);
		end else if (seq_phase == PH_POWER) begin
			// a zero dummy count acts as one
			if (dummies < cfg_power_up) begin
				dummies = dummies + 8'd1;
				r = spi_beat(SPI_IDLE_BYTE, 1'b0);
			end else begin
				tries = 16'd0;
				r = open_command(CMD_0);
			end
		end else if (seq_phase >= 4'd1 && seq_phase <= PH_LAST_CMD) begin
			if (seq_phase[0]) begin
				frame_pos = frame_pos + 4'd1;
				if (frame_pos < ((c == CMD_0) ? 4'd7 : 4'd6)) begin
					r = spi_beat(frame_byte(c, frame_pos), 1'b1);
				end else begin
					seq_phase = seq_phase + 4'd1;
					poll_no = 4'd0;
					r = spi_beat(SPI_IDLE_BYTE, 1'b1);
				end
			end else begin
				poll_no = poll_no + 4'd1;
				hit = ((c == CMD_0) && (rx == CMD0_IDLE_ANSWER)) ||
					((c == CMD_55 || c == CMD_ACMD41) && (rx == CARD_OK_ANSWER));
				if (!hit && poll_no < POLL_LIMITS[4 * c +: 4]) begin
					r = spi_beat(SPI_IDLE_BYTE, 1'b1);
				end else begin
					case (c)
						CMD_0: begin
							if (hit) begin
								r = open_command(CMD_8);
							end else if (attempts_spent()) begin
								seq_phase = PH_FAIL_CMD0;
								r = quiet_beat();
							end else begin
								r = open_command(CMD_0);
							end
						end
						CMD_8: r = open_command(CMD_58);
						CMD_58: begin
							tries = 16'd0;
							r = open_command(CMD_55);
						end
						CMD_55: r = open_command(CMD_ACMD41);
						default: begin
							// success on the last allowed pair still counts
							if (hit) begin
								seq_phase = PH_READY;
								r = quiet_beat();
							end else if (attempts_spent()) begin
								seq_phase = PH_FAIL_ACMD41;
								r = quiet_beat();
							end else begin
								r = open_command(CMD_55);
							end
						end
					endcase
				end
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- card model
	// Picks the byte the card returns on the exchange now pending, from the
	// predicted phase. Command bytes and plain reads get mostly 0xFF with some
	// junk; polls answer the stop value with the given odds (CMD55: even odds).
	function automatic logic [7:0] card_answer(input int cmd0_pct, input int acmd41_pct);
		logic [7:0] noise;
		logic hit;
		int pick;
		pick = $urandom_range(7);
		noise = 8'hFF;
		if (pick < 2)
			noise = 8'($urandom_range(255));
		else if (pick == 2)
			noise = CARD_OK_ANSWER;
		else if (pick == 3)
			noise = CMD0_IDLE_ANSWER;
		case (seq_phase)
			PH_CMD0_POLL: begin
				hit = last_try_card ? (tries == cfg_max_attempts - 16'd1)
					: ($urandom_range(99) < cmd0_pct);
				if (noise == CMD0_IDLE_ANSWER)
					noise = 8'hFF;
			end
			PH_CMD55_POLL: begin
				hit = 1'($urandom_range(1));
				if (noise == CARD_OK_ANSWER)
					noise = 8'hFF;
			end
			PH_ACMD41_POLL: begin
				hit = last_try_card ? (tries == cfg_max_attempts - 16'd1)
					: ($urandom_range(99) < acmd41_pct);
				if (noise == CARD_OK_ANSWER)
					noise = 8'hFF;
			end
			default: hit = 1'b0;
		endcase
		if (hit)
			return (seq_phase == PH_CMD0_POLL) ? CMD0_IDLE_ANSWER : CARD_OK_ANSWER;
		return noise;
	endfunction

	// ---------------------------------------------------------------- sender side
	// Bursts of random length with random gaps; gaps_on off gives a steady stream.
	function automatic int next_gap();
		if (!gaps_on)
			return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(1, 24);
		return ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// valid is left high so that back-to-back beats never toggle it within one step.
	task automatic send_report(input logic k, input logic [7:0] rx);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		rx_byte <= rx;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		predicted_beats.push_back(sequencer_step(k, rx));
		@(negedge clk);
	endtask

	// Stop offering beats and wait until every owed result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (predicted_beats.size() != 0)
			@(negedge clk);
	endtask

	// APB write: setup cycle, then access; the register takes it at the access edge
	task automatic write_register(input logic idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (idx == REG_MAX_ATTEMPTS)
			cfg_max_attempts = data[15:0];
		else
			cfg_power_up = data[7:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Registers only change with the pipeline empty; a few spare cycles cover
	// the two pipeline stages of the block.
	task automatic apply_settings(input logic [15:0] max_attempts, input logic [7:0] power_up);
		wait_drained();
		repeat (4) @(negedge clk);
		write_register(REG_MAX_ATTEMPTS, {16'd0, max_attempts});
		write_register(REG_POWER_UP_BYTES, {24'd0, power_up});
	endtask

	// Whole start-up sessions: start, then the card's replies until the
	// sequencer finishes. Now and then a stray report after the end, or a
	// start in the middle of a session. Stray reports are not counted.
	task automatic run_card_sessions(input int beats, input int cmd0_pct, input int acmd41_pct);
		int counted;
		logic [7:0] rx;
		counted = 0;
		while (counted < beats) begin
			rx = 8'($urandom_range(255));
			if (seq_phase == PH_IDLE || seq_phase >= PH_READY) begin
				if ($urandom_range(4) == 0) begin
					send_report(1'b1, rx);
				end else begin
					send_report(1'b0, rx);
					counted++;
				end
			end else if ($urandom_range(249) == 0) begin
				send_report(1'b0, rx);
				counted++;
			end else begin
				send_report(1'b1, card_answer(cmd0_pct, acmd41_pct));
				counted++;
			end
		end
	endtask

	// ---------------------------------------------------------------- receiver side
	// Own ready pattern: steady, coin-flip or periodic stretches, plus a long
	// hold-off whenever a test asks for one.
	always @(negedge clk) begin : receiver_pattern
		if (holds_served != holds_requested) begin
			holds_served = holds_requested;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_mode = $urandom_range(2);
				pattern_left = $urandom_range(4, 64);
			end
			pattern_left--;
			case (pattern_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(1));
				default: out_ready <= (pattern_left % 3) != 0;
			endcase
		end
	end

	// ---------------------------------------------------------------- checking
	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Every result beat is scored against the oldest prediction.
	always @(posedge clk) begin : result_check
		sdi_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (predicted_beats.size() == 0) begin
				$error("result beat with nothing expected: tx_byte %0h", tx_byte);
				mismatches++;
			end else begin
				want = predicted_beats.pop_front();
				check_field("tx_byte", want.tx_byte, tx_byte);
				check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, tx_valid});
				check_field("select_active", {7'd0, want.select_active},
					{7'd0, select_active});
				check_field("status", {6'd0, want.status}, {6'd0, status});
			end
		end
	end

	// Any handshake counts as progress; a long run without one is a hang.
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1 ||
				(psel && penable))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= STALL_LIMIT) begin
			$display("sd_spi_card_initializer: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// Exchange reports before any start: no exchange, status busy.
	task automatic test_idle_reports();
		send_report(1'b1, 8'h00);
		send_report(1'b1, 8'hFF);
	endtask

	// Smallest budget and a zero dummy count: one dummy, one CMD0 attempt whose
	// two polls miss, then a report after the timeout.
	task automatic test_cmd0_timeout();
		apply_settings(16'd1, 8'd0);
		send_report(1'b0, 8'h5A);
		repeat (8) send_report(1'b1, 8'hFF);
		send_report(1'b1, 8'h00);
		send_report(1'b1, 8'hFE);
		send_report(1'b1, CMD0_IDLE_ANSWER);
	endtask

	// Start again in the middle of the CMD0 frame.
	task automatic test_restart_midway();
		send_report(1'b0, 8'h00);
		repeat (3) send_report(1'b1, 8'hFF);
		send_report(1'b0, 8'hFF);
		send_report(1'b1, 8'h01);
	endtask

	task automatic test_default_settings();
		apply_settings(MAX_ATTEMPTS_RST, POWER_UP_BYTES_RST);
		run_card_sessions(400, 60, 35);
	endtask

	// Budget of one: a single missed CMD0 or ACMD41 attempt ends in a timeout.
	task automatic test_minimum_settings();
		apply_settings(16'd1, 8'd1);
		run_card_sessions(300, 50, 50);
	endtask

	task automatic test_long_power_up();
		apply_settings(16'd3, 8'd255);
		run_card_sessions(350, 40, 40);
	endtask

	task automatic test_maximum_attempts();
		apply_settings(16'hFFFF, 8'd2);
		run_card_sessions(300, 30, 30);
	endtask

	// Zero in both registers acts as one.
	task automatic test_zero_settings();
		apply_settings(16'd0, 8'd0);
		run_card_sessions(200, 50, 50);
	endtask

	// Card answers on the final allowed CMD0 attempt and CMD55/ACMD41 pair.
	task automatic test_last_attempt_success();
		apply_settings(16'd2, 8'd1);
		last_try_card = 1'b1;
		run_card_sessions(150, 0, 0);
		last_try_card = 1'b0;
	endtask

	// Receiver holds off while the sender streams without gaps, so the block
	// backs up and drops in_ready.
	task automatic test_backpressure();
		apply_settings(16'd4, 8'd3);
		gaps_on = 1'b0;
		holds_requested++;
		run_card_sessions(150, 50, 50);
		gaps_on = 1'b1;
	endtask

	// Sender goes quiet until every result is out, then carries on.
	task automatic test_drain_pause();
		run_card_sessions(60, 50, 50);
		wait_drained();
		run_card_sessions(60, 50, 50);
	endtask

	initial begin : test_sequence
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_reports();
		test_cmd0_timeout();
		test_restart_midway();
		test_default_settings();
		test_minimum_settings();
		test_long_power_up();
		test_maximum_attempts();
		test_zero_settings();
		test_last_attempt_success();
		test_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("sd_spi_card_initializer: match");
		else
			$display("sd_spi_card_initializer: mismatch");
		$finish;
	end

endmodule
